// File: src/kcf_pkg.sv
package kcf_pkg;

  localparam int BoneCount = 16;
  localparam int IdxW      = (BoneCount > 1) ? $clog2(BoneCount) : 1;
  localparam int CntW      = $clog2(BoneCount + 1);

  localparam int CoordW  = 24;
  localparam int AngleW  = 16;
  localparam int BlendW  = 17;
  localparam int LengthW = 16;
  localparam int BoneIdxW = 6;

  localparam int ZW      = 21;
  localparam int XyW     = 19;
  localparam int CordicSteps = 16;
  localparam int StepW   = 4;

  localparam logic signed [ZW-1:0] Q16Pi     = 21'sd205887;
  localparam logic signed [ZW-1:0] Q16HalfPi = 21'sd102944;
  localparam logic signed [ZW-1:0] Q16TwoPi  = 21'sd411775;
  localparam logic signed [XyW-1:0] CordicGain = 19'sd39797;

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = -24'sh800000;

  localparam logic [0:0] ActInit = 1'b0;
  localparam logic [0:0] ActMove = 1'b1;

  localparam logic [0:0] RegBlend  = 1'b0;
  localparam logic [0:0] RegLength = 1'b1;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:    r = 21'sd51472;
      4'd1:    r = 21'sd30386;
      4'd2:    r = 21'sd16055;
      4'd3:    r = 21'sd8150;
      4'd4:    r = 21'sd4091;
      4'd5:    r = 21'sd2047;
      4'd6:    r = 21'sd1024;
      4'd7:    r = 21'sd512;
      4'd8:    r = 21'sd256;
      4'd9:    r = 21'sd128;
      4'd10:   r = 21'sd64;
      4'd11:   r = 21'sd32;
      4'd12:   r = 21'sd16;
      4'd13:   r = 21'sd8;
      4'd14:   r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

endpackage

// File: src/kinematic_chain_follow.sv
// kinematic_chain_follow: a chain of kcf_pkg::BoneCount equal bones whose angles live in a
// one-port synchronous memory. An init item (action 0) writes the given angle into every
// entry, one per cycle, and yields no result. A move item (action 1) yields one result
// per bone, root first: the angle is read, blended toward the parent's angle
// (multiply, then register), turned into cos/sin by a shared 16-step CORDIC (one step a
// cycle), scaled by the bone length (two registered multiplies) and added to the bone
// start with saturation; the new angle is written back. A move stalls in its output
// state while the previous result has not been taken.
// The angle memory resets to zero through a clearing pass over all BoneCount entries after
// reset, during which no item is accepted. Registers: angle_blend at 0x0 (values above
// 65536 act as 65536), bone_length at 0x4.
module kinematic_chain_follow (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic action_i,
  input  logic signed [kcf_pkg::CoordW-1:0] target_x_i,
  input  logic signed [kcf_pkg::CoordW-1:0] target_y_i,
  input  logic signed [kcf_pkg::AngleW-1:0] target_angle_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [kcf_pkg::BoneIdxW-1:0] bone_index_o,
  output logic signed [kcf_pkg::CoordW-1:0] start_x_o,
  output logic signed [kcf_pkg::CoordW-1:0] start_y_o,
  output logic signed [kcf_pkg::CoordW-1:0] end_x_o,
  output logic signed [kcf_pkg::CoordW-1:0] end_y_o,
  output logic signed [kcf_pkg::AngleW-1:0] bone_angle_o,
  output logic last_bone_o
);
  import kcf_pkg::*;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StInit  = 4'd2;
  localparam logic [3:0] StRead  = 4'd3;
  localparam logic [3:0] StBlend = 4'd4;
  localparam logic [3:0] StSat   = 4'd5;
  localparam logic [3:0] StFold  = 4'd6;
  localparam logic [3:0] StCord  = 4'd7;
  localparam logic [3:0] StMulX  = 4'd8;
  localparam logic [3:0] StMulY  = 4'd9;
  localparam logic [3:0] StEnd   = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [BlendW-1:0]  blend_q;
  logic [LengthW-1:0] length_q;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q  <= BlendW'(32768);
      length_q <= LengthW'(2560);
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegBlend) blend_q <= pwdata[BlendW-1:0];
      else                      length_q <= pwdata[LengthW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegBlend) prdata = 32'(blend_q);
      else                      prdata = 32'(length_q);
    end
  end

  // Angle memory
  logic signed [AngleW-1:0] mem [BoneCount];
  logic signed [AngleW-1:0] rd_q;
  logic mem_we;
  logic [IdxW-1:0] mem_addr;
  logic signed [AngleW-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  // Datapath registers
  logic [CntW-1:0] bone_q;
  logic signed [AngleW-1:0] parent_q, ta_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [CoordW-1:0] run_x_q, run_y_q;
  logic signed [34:0] prod_q;
  logic signed [AngleW-1:0] ang_q;
  logic signed [ZW-1:0] z_q;
  logic signed [XyW-1:0] cx_q, cy_q;
  logic flip_q;
  logic [StepW-1:0] step_q;
  logic signed [36:0] mul_q;
  logic signed [CoordW+1:0] dx_q;

  logic signed [17:0] diff;
  logic signed [BlendW:0] w_eff;
  logic signed [ZW-1:0] z0, zf;
  logic fl;
  logic signed [XyW-1:0] sh_x, sh_y, tx_sel;
  logic signed [36:0] rnd;
  logic signed [CoordW+1:0] sum;
  logic signed [CoordW-1:0] sat;
  logic signed [18:0] bl_v;
  logic last;

  assign last = (bone_q == CntW'(BoneCount - 1));
  assign w_eff = (blend_q > BlendW'(65536)) ? (BlendW+1)'(65536) : (BlendW+1)'(blend_q);
  assign diff = 18'(rd_q) - 18'(parent_q);
  assign bl_v = 19'(parent_q) + 19'(prod_q[34:16]);

  always_comb begin
    z0 = ZW'(ang_q) <<< 4;
    zf = z0;
    if (z0 > Q16Pi) zf = z0 - Q16TwoPi;
    else if (z0 < -Q16Pi) zf = z0 + Q16TwoPi;
    fl = 1'b0;
    if (zf > Q16HalfPi) begin
      zf = zf - Q16Pi;
      fl = 1'b1;
    end else if (zf < -Q16HalfPi) begin
      zf = zf + Q16Pi;
      fl = 1'b1;
    end
  end

  assign sh_x = cx_q >>> step_q;
  assign sh_y = cy_q >>> step_q;
  assign tx_sel = (state_q == StMulX) ? (flip_q ? -cx_q : cx_q) : (flip_q ? -cy_q : cy_q);
  assign rnd = mul_q + 37'sd32768;

  always_comb begin
    sum = (CoordW+2)'(sx_q) + dx_q;
    if (state_q == StOut) sum = (CoordW+2)'(sy_q) + dx_q;
    if (sum > (CoordW+2)'(CoordMax)) sat = CoordMax;
    else if (sum < (CoordW+2)'(CoordMin)) sat = CoordMin;
    else sat = sum[CoordW-1:0];
  end

  logic out_fire;
  assign out_fire = out_valid_o & out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = bone_q[IdxW-1:0];
    mem_wd = ta_q;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      StInit: mem_we = 1'b1;
      StFold: begin
        mem_we = 1'b1;
        mem_wd = ang_q;
      end
      default: ;
    endcase
  end

  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (last) state_d = StIdle;
      StIdle: if (in_valid_i) state_d = (action_i == ActInit) ? StInit : StRead;
      StInit: if (last) state_d = StIdle;
      StRead:  state_d = StBlend;
      StBlend: state_d = StSat;
      StSat:   state_d = StFold;
      StFold:  state_d = StCord;
      StCord:  if (step_q == StepW'(CordicSteps - 1)) state_d = StMulX;
      StMulX:  state_d = StMulY;
      StMulY:  state_d = StEnd;
      StEnd:   state_d = StOut;
      StOut:   if (!out_valid_q || out_fire)
                 state_d = last ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      bone_q <= '0;
      out_valid_q <= 1'b0;
      run_x_q <= '0;
      run_y_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && (!out_valid_q || out_fire)) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear, StInit: bone_q <= last ? '0 : bone_q + 1'b1;
        StIdle: bone_q <= '0;
        StOut: if (!out_valid_q || out_fire) begin
          bone_q <= bone_q + 1'b1;
          if (bone_q == CntW'(BoneCount - 1)) begin
            run_x_q <= ex_q;
            run_y_q <= sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        ta_q <= target_angle_i;
        parent_q <= target_angle_i;
        sx_q <= target_x_i;
        sy_q <= target_y_i;
        step_q <= '0;
      end
      StBlend: prod_q <= 35'(diff) * 35'(w_eff) + 35'sd32768;
      StSat: begin
        if (bl_v > 19'sd32767) ang_q <= 16'sh7FFF;
        else if (bl_v < -19'sd32768) ang_q <= -16'sh8000;
        else ang_q <= bl_v[AngleW-1:0];
      end
      StFold: begin
        z_q <= zf;
        flip_q <= fl;
        cx_q <= CordicGain;
        cy_q <= '0;
        step_q <= '0;
      end
      StCord: begin
        if (z_q >= 0) begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          z_q <= z_q - atan_q16(step_q);
        end else begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          z_q <= z_q + atan_q16(step_q);
        end
        step_q <= step_q + 1'b1;
      end
      StMulX: mul_q <= 37'($signed({1'b0, length_q})) * 37'(tx_sel);
      StMulY: begin
        dx_q <= (CoordW+2)'(rnd >>> 16);
        mul_q <= 37'($signed({1'b0, length_q})) * 37'(tx_sel);
      end
      StEnd: begin
        ex_q <= sat;
        dx_q <= (CoordW+2)'(rnd >>> 16);
      end
      StOut: if (!out_valid_q || out_fire) begin
        bone_index_o <= BoneIdxW'(bone_q);
        start_x_o <= sx_q;
        start_y_o <= sy_q;
        end_x_o <= ex_q;
        end_y_o <= sat;
        bone_angle_o <= ang_q;
        last_bone_o <= (bone_q == CntW'(BoneCount - 1));
        parent_q <= ang_q;
        sx_q <= ex_q;
        sy_q <= sat;
      end
      default: ;
    endcase
  end

  logic unused;
  assign unused = ^{run_x_q, run_y_q, pwdata};

endmodule
